// ----- sv/tdpt_pkg.sv -----
// ---------------------------------------------------------------------------
// tdpt_pkg
// types and constants shared by the trial-division prime tester
// ---------------------------------------------------------------------------
package tdpt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF  = 8192;
  localparam int unsigned NUMBER_WIDTH_DEF = 32;
  localparam int unsigned PRIME_W          = 16;
  localparam int unsigned COUNT_W          = 32;
  localparam int unsigned LIMIT_W          = 16;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_TEST    = 1'b1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 32'd4;

  typedef struct packed {
    logic        kind;
    logic [31:0] number;
  } in_item_t;

  typedef struct packed {
    logic        prime_flag;
    logic [31:0] prime_count;
    logic        table_full;
  } out_item_t;

endpackage

// ----- sv/tdpt_ram.sv -----
// ---------------------------------------------------------------------------
// tdpt_ram
// single-port synchronous ram with registered read
// ---------------------------------------------------------------------------
module tdpt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/tdpt_divider.sv -----
// ---------------------------------------------------------------------------
// tdpt_divider
// restoring remainder unit, one quotient bit per cycle
// ---------------------------------------------------------------------------
module tdpt_divider
  import tdpt_pkg::*;
#(
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NUMBER_WIDTH-1:0] dividend,
  input  logic [PRIME_W-1:0]      divisor,
  output logic                    done,
  output logic                    rem_zero
);

  localparam int unsigned CW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] shreg_r, shreg_nxt;
  logic [PRIME_W:0]        rem_r, rem_nxt;
  logic [PRIME_W-1:0]      dvs_r, dvs_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [PRIME_W+1:0]      trial;

  always_comb begin
    shreg_nxt = shreg_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    done_nxt  = 1'b0;
    trial     = {rem_r, shreg_r[NUMBER_WIDTH-1]} - {2'b00, dvs_r};
    if (start) begin
      shreg_nxt = dividend;
      rem_nxt   = '0;
      dvs_nxt   = divisor;
      cnt_nxt   = CW'(NUMBER_WIDTH);
      run_nxt   = 1'b1;
    end else if (run_r) begin
      // keep the partial remainder below the divisor
      if (!trial[PRIME_W+1]) begin
        rem_nxt = trial[PRIME_W:0];
      end else begin
        rem_nxt = {rem_r[PRIME_W-1:0], shreg_r[NUMBER_WIDTH-1]};
      end
      shreg_nxt = {shreg_r[NUMBER_WIDTH-2:0], 1'b0};
      cnt_nxt   = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    shreg_r <= shreg_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
  end

  assign done     = done_r;
  assign rem_zero = (rem_r == '0);

endmodule

// ----- sv/trial_division_prime_tester.sv -----
// ---------------------------------------------------------------------------
// trial_division_prime_tester
// tests odd candidates by trial division against a ram table of odd primes
// ---------------------------------------------------------------------------
//  channel  ports                       transaction
//  in       start, busy, in_item        start high while busy low
//  out      out_valid, out_item         one cycle strobe, cannot be held off
//  cfg      cfg_we, cfg_data            divider_limit, written when cfg_we
//
//  a test keeps busy high while the bit-serial remainder unit divides the
//  candidate by the table primes in turn. a restart seeds three entries
//  through the ram port. after reset the table is seeded before busy falls.
//  the result strobe comes in the first idle cycle. the receiver cannot stall.
// ---------------------------------------------------------------------------
module trial_division_prime_tester
  import tdpt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_item,
  output logic                out_valid,
  output out_item_t           out_item,
  input  logic                cfg_we,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned FW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_SEED  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              seed_r, seed_nxt;
  logic [FW-1:0]           fill_r, fill_nxt;
  logic [FW-1:0]           idx_r, idx_nxt;
  logic [PRIME_W-1:0]      last_r, last_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [LIMIT_W-1:0]      limit_r;
  logic [NUMBER_WIDTH-1:0] num_r, num_nxt;
  logic                    prime_r, prime_nxt;
  logic                    restart_r, restart_nxt;
  logic                    ovalid_r, ovalid_nxt;
  logic                    oprime_r, oprime_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [PRIME_W-1:0] ram_wdata, ram_rdata;
  logic               div_start, div_done, div_zero;
  logic [2*PRIME_W-1:0] sq;
  logic [PRIME_W-1:0] seed_val;

  tdpt_ram #(.WIDTH(PRIME_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  tdpt_divider #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (ram_rdata),
    .done     (div_done),
    .rem_zero (div_zero)
  );

  assign sq = ram_rdata * ram_rdata;

  always_comb begin
    unique case (seed_r)
      2'd0:    seed_val = PRIME_W'(3);
      2'd1:    seed_val = PRIME_W'(5);
      default: seed_val = PRIME_W'(7);
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    seed_nxt    = seed_r;
    fill_nxt    = fill_r;
    idx_nxt     = idx_r;
    last_nxt    = last_r;
    count_nxt   = count_r;
    num_nxt     = num_r;
    prime_nxt   = prime_r;
    restart_nxt = restart_r;
    ovalid_nxt  = 1'b0;
    oprime_nxt  = oprime_r;
    ram_we      = 1'b0;
    ram_addr    = idx_r[AW-1:0];
    ram_wdata   = seed_val;
    div_start   = 1'b0;
    unique case (state_r)
      ST_SEED: begin
        ram_we   = 1'b1;
        ram_addr = AW'(seed_r);
        seed_nxt = seed_r + 2'd1;
        if (seed_r == 2'd2) begin
          seed_nxt  = 2'd0;
          fill_nxt  = FW'(3);
          last_nxt  = PRIME_W'(7);
          count_nxt = COUNT_RESET;
          if (restart_r) begin
            restart_nxt = 1'b0;
            oprime_nxt  = 1'b0;
            ovalid_nxt  = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_item.kind == KIND_RESTART) begin
            restart_nxt = 1'b1;
            state_nxt   = ST_SEED;
          end else begin
            num_nxt   = in_item.number[NUMBER_WIDTH-1:0];
            idx_nxt   = '0;
            prime_nxt = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        // walk ends as prime past the filled table
        if (idx_r >= fill_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if ({{(32+NUMBER_WIDTH-2*PRIME_W){1'b0}}, sq} >
            {32'd0, num_r}) begin
          state_nxt = ST_DONE;
        end else if (ram_rdata == '0) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (div_zero) begin
            prime_nxt = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_DONE: begin
        oprime_nxt = prime_r;
        ovalid_nxt = 1'b1;
        state_nxt  = ST_IDLE;
        if (prime_r) begin
          count_nxt = count_r + 1'b1;
          if ({{(32+NUMBER_WIDTH-LIMIT_W){1'b0}}, limit_r} >= {32'd0, num_r} &&
              fill_r < FW'(TABLE_DEPTH) &&
              {32'd0, num_r} > {{(32+NUMBER_WIDTH-PRIME_W){1'b0}}, last_r}) begin
            ram_we    = 1'b1;
            ram_addr  = fill_r[AW-1:0];
            ram_wdata = num_r[PRIME_W-1:0];
            last_nxt  = num_r[PRIME_W-1:0];
            fill_nxt  = fill_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_SEED;
      seed_r    <= 2'd0;
      fill_r    <= FW'(3);
      last_r    <= PRIME_W'(7);
      count_r   <= COUNT_RESET;
      limit_r   <= LIMIT_RESET;
      restart_r <= 1'b0;
      ovalid_r  <= 1'b0;
      idx_r     <= '0;
      prime_r   <= 1'b0;
      oprime_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seed_r    <= seed_nxt;
      fill_r    <= fill_nxt;
      last_r    <= last_nxt;
      count_r   <= count_nxt;
      restart_r <= restart_nxt;
      ovalid_r  <= ovalid_nxt;
      idx_r     <= idx_nxt;
      prime_r   <= prime_nxt;
      oprime_r  <= oprime_nxt;
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
    end
    num_r <= num_nxt;
  end

  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = ovalid_r;
  assign out_item.prime_flag  = oprime_r;
  assign out_item.prime_count = count_r;
  assign out_item.table_full  = (fill_r >= FW'(TABLE_DEPTH));

endmodule
